// ===== design/mfle_pkg.sv =====
// Shared constants, codes and types of the monochrome frame buffer line engine.
package mfle_pkg;

    // Frame geometry
    localparam int FB_WIDTH   = 128;
    localparam int FB_HEIGHT  = 64;
    localparam int PAGE_ROWS  = 8;
    localparam int PAGE_SHIFT = $clog2(PAGE_ROWS);
    localparam int NUM_PAGES  = (FB_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;

    // Frame store: one byte per page column, bit j is row page*8+j
    localparam int MEM_DEPTH  = NUM_PAGES * FB_WIDTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int BYTE_W     = 8;

    // Datapath widths
    localparam int COORD_W    = 11;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int ERR_W      = COORD_W + 3;
    localparam int CLIP_W     = COORD_W + 2;
    localparam int PAGE_W     = 3;
    localparam int COL_W      = 7;

    // Port widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_LINE  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } req_kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd4;

    // Reset values of the clip rectangle
    localparam logic [COORD_W-1:0] CLIP_WIDTH_RST  = 11'd128;
    localparam logic [COORD_W-1:0] CLIP_HEIGHT_RST = 11'd64;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_ERR_INIT,
        ST_WALK,
        ST_DRAIN,
        ST_CLEAR,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

endpackage

// ===== design/mono_framebuffer_line_engine.sv =====
// Top level: request sequencer, Bresenham walker and read-modify-write of the frame store.
//
//  channel | dir | beat fields
//  --------+-----+-----------------------------------------------------------------
//  s_      | in  | tuser: req_type; tdata: x/y start, x/y end, value, page, column,
//          |     | clear_dirty
//  m_      | out | tdata: read_byte, dirty (one beat per request)
//  cfg_    | in  | cfg_index selects a clip register, cfg_wdata is written
//
// Line or set pixel: the walker issues one pixel per cycle and the frame store
// read-modify-write overlaps the next pixel. Clear: one frame store byte per cycle.
// Read: the addressed byte is fetched and registered for the result beat.
// After reset a clearing pass over all 1024 frame store bytes runs with s_tready low.
// A waiting result does not block the next request; it only holds the finish
// of the following one until m_tready takes the beat.
module mono_framebuffer_line_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [10:0] x_start, [21:11] y_start, [32:22] x_end, [43:33] y_end,
    // [44] pixel_value, [47:45] read_page, [54:48] read_column, [55] clear_dirty
    input  logic [mfle_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  logic [mfle_pkg::REQ_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] read_byte, [8] dirty, [15:9] zero
    output logic [mfle_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [mfle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfle_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW = mfle_pkg::COORD_W;
    localparam int AW = mfle_pkg::ADDR_W;
    localparam int BW = mfle_pkg::BYTE_W;

    // Sequencer
    mfle_pkg::state_t state_reg, state_next;

    // Clip registers
    logic                 clip_en_reg;
    logic signed [CW-1:0] clip_left_reg;
    logic signed [CW-1:0] clip_top_reg;
    logic [CW-1:0]        clip_width_reg;
    logic [CW-1:0]        clip_height_reg;

    // Request registers; x_reg/y_reg also hold the walk position
    logic signed [CW-1:0]        x_reg, y_reg, xe_reg, ye_reg;
    logic                        val_reg;
    logic [mfle_pkg::PAGE_W-1:0] page_reg;
    logic [mfle_pkg::COL_W-1:0]  col_reg;

    // Bresenham terms
    logic [mfle_pkg::DELTA_W-1:0]      dx_reg, dy_reg;
    logic                              x_neg_reg, y_neg_reg;
    logic signed [mfle_pkg::ERR_W-1:0] err_reg;

    // Write-back stage
    logic                         pb_valid_reg;
    logic [AW-1:0]                pb_addr_reg;
    logic [mfle_pkg::PAGE_SHIFT-1:0] pb_bit_reg;
    logic                         pb_val_reg;
    logic                         last_we_reg;
    logic [AW-1:0]                last_waddr_reg;
    logic [BW-1:0]                last_wdata_reg;

    // Misc
    logic [AW-1:0] clr_cnt_reg;
    logic          dirty_reg;
    logic [BW-1:0] rbyte_reg;
    logic          m_tvalid_reg;
    logic [mfle_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [BW-1:0] ram_wdata, ram_rdata;

    // Combinational terms
    logic                                s_accept;
    mfle_pkg::req_kind_t                 in_req;
    logic signed [mfle_pkg::DELTA_W-1:0] diff_x, diff_y;
    logic signed [mfle_pkg::ERR_W:0]     e2, neg_dy, pos_dx;
    logic                                step_x, step_y, at_end;
    logic signed [mfle_pkg::ERR_W:0]     err_sum;
    logic                                x_on, y_on, x_clip, y_clip, pix_ok;
    logic signed [mfle_pkg::CLIP_W-1:0]  xw, yw, cl_w, ct_w, cr_w, cb_w;
    logic [AW-1:0]                       pix_addr, rd_addr;
    logic                                rd_ok;
    logic                                fwd;
    logic [BW-1:0]                       cur_byte, new_byte;
    logic                                clr_last;
    logic                                out_free;

    mfle_ram #(
        .WIDTH (BW),
        .DEPTH (mfle_pkg::MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_req   = mfle_pkg::req_kind_t'(s_tuser);
    assign s_accept = s_tvalid && s_tready;
    assign clr_last = (clr_cnt_reg == AW'(mfle_pkg::MEM_DEPTH - 1));
    assign out_free = !m_tvalid_reg || m_tready;

    // Line setup: signed deltas
    assign diff_x = {xe_reg[CW-1], xe_reg} - {x_reg[CW-1], x_reg};
    assign diff_y = {ye_reg[CW-1], ye_reg} - {y_reg[CW-1], y_reg};

    // Bresenham step decision
    assign e2      = {err_reg, 1'b0};
    assign neg_dy  = -$signed({3'b000, dy_reg});
    assign pos_dx  = $signed({3'b000, dx_reg});
    assign step_x  = (e2 > neg_dy);
    assign step_y  = (e2 < pos_dx);
    assign err_sum = {err_reg[mfle_pkg::ERR_W-1], err_reg}
                     + (step_x ? neg_dy : '0) + (step_y ? pos_dx : '0);
    assign at_end  = (x_reg == xe_reg) && (y_reg == ye_reg);

    // Screen and clip tests for the current walk position
    assign x_on   = !x_reg[CW-1] && (unsigned'(x_reg) < CW'(mfle_pkg::FB_WIDTH));
    assign y_on   = !y_reg[CW-1] && (unsigned'(y_reg) < CW'(mfle_pkg::FB_HEIGHT));
    assign xw     = mfle_pkg::CLIP_W'(x_reg);
    assign yw     = mfle_pkg::CLIP_W'(y_reg);
    assign cl_w   = mfle_pkg::CLIP_W'(clip_left_reg);
    assign ct_w   = mfle_pkg::CLIP_W'(clip_top_reg);
    assign cr_w   = cl_w + $signed({2'b00, clip_width_reg});
    assign cb_w   = ct_w + $signed({2'b00, clip_height_reg});
    assign x_clip = (xw >= cl_w) && (xw < cr_w);
    assign y_clip = (yw >= ct_w) && (yw < cb_w);
    assign pix_ok = x_on && y_on && (!clip_en_reg || (x_clip && y_clip));

    // Byte addresses
    assign pix_addr = AW'((unsigned'(y_reg) >> mfle_pkg::PAGE_SHIFT) * mfle_pkg::FB_WIDTH
                          + unsigned'(x_reg));
    assign rd_addr  = AW'(page_reg * mfle_pkg::FB_WIDTH + col_reg);
    assign rd_ok    = (int'(page_reg) < mfle_pkg::NUM_PAGES)
                      && (int'(col_reg) < mfle_pkg::FB_WIDTH);

    // Read-modify-write with forwarding of the previous cycle's write
    assign fwd      = last_we_reg && (last_waddr_reg == pb_addr_reg);
    assign cur_byte = fwd ? last_wdata_reg : ram_rdata;
    assign new_byte = (cur_byte & ~(BW'(1) << pb_bit_reg))
                      | (BW'(pb_val_reg) << pb_bit_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mfle_pkg::ST_INIT: begin
                if (clr_last) state_next = mfle_pkg::ST_IDLE;
            end
            mfle_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_req)
                        mfle_pkg::REQ_CLEAR: state_next = mfle_pkg::ST_CLEAR;
                        mfle_pkg::REQ_READ:  state_next = mfle_pkg::ST_READ;
                        default:             state_next = mfle_pkg::ST_SETUP;
                    endcase
                end
            end
            mfle_pkg::ST_SETUP:     state_next = mfle_pkg::ST_ERR_INIT;
            mfle_pkg::ST_ERR_INIT:  state_next = mfle_pkg::ST_WALK;
            mfle_pkg::ST_WALK: begin
                if (at_end) state_next = mfle_pkg::ST_DRAIN;
            end
            mfle_pkg::ST_DRAIN:     state_next = mfle_pkg::ST_DONE;
            mfle_pkg::ST_CLEAR: begin
                if (clr_last) state_next = mfle_pkg::ST_DONE;
            end
            mfle_pkg::ST_READ:      state_next = mfle_pkg::ST_READ_DATA;
            mfle_pkg::ST_READ_DATA: state_next = mfle_pkg::ST_DONE;
            mfle_pkg::ST_DONE: begin
                if (out_free) state_next = mfle_pkg::ST_IDLE;
            end
            default:                state_next = mfle_pkg::ST_IDLE;
        endcase
    end

    // State-driven outputs: handshake and RAM port
    always_comb begin
        s_tready  = (state_reg == mfle_pkg::ST_IDLE);
        ram_we    = pb_valid_reg;
        ram_waddr = pb_addr_reg;
        ram_wdata = new_byte;
        ram_raddr = pix_addr;
        case (state_reg)
            mfle_pkg::ST_INIT, mfle_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            mfle_pkg::ST_READ: begin
                ram_raddr = rd_addr;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mfle_pkg::ST_INIT;
            clr_cnt_reg  <= '0;
            pb_valid_reg <= 1'b0;
            last_we_reg  <= 1'b0;
            dirty_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pb_valid_reg <= (state_reg == mfle_pkg::ST_WALK) && pix_ok;
            last_we_reg  <= pb_valid_reg;

            // Clearing sweep counter
            if (state_reg == mfle_pkg::ST_INIT || state_reg == mfle_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + AW'(1);
            end

            // Sticky dirty flag
            if (s_accept && s_tdata[55]) begin
                dirty_reg <= 1'b0;
            end else if (pb_valid_reg || state_reg == mfle_pkg::ST_CLEAR) begin
                dirty_reg <= 1'b1;
            end

            // Output register
            if (state_reg == mfle_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_en_reg     <= 1'b0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_width_reg  <= mfle_pkg::CLIP_WIDTH_RST;
            clip_height_reg <= mfle_pkg::CLIP_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mfle_pkg::CFG_CLIP_ENABLE: clip_en_reg     <= cfg_wdata[0];
                mfle_pkg::CFG_CLIP_LEFT:   clip_left_reg   <= $signed(cfg_wdata);
                mfle_pkg::CFG_CLIP_TOP:    clip_top_reg    <= $signed(cfg_wdata);
                mfle_pkg::CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_wdata;
                mfle_pkg::CFG_CLIP_HEIGHT: clip_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        pb_addr_reg    <= pix_addr;
        pb_bit_reg     <= y_reg[mfle_pkg::PAGE_SHIFT-1:0];
        pb_val_reg     <= val_reg;
        last_waddr_reg <= pb_addr_reg;
        last_wdata_reg <= new_byte;

        case (state_reg)
            mfle_pkg::ST_IDLE: begin
                if (s_accept) begin
                    x_reg     <= $signed(s_tdata[10:0]);
                    y_reg     <= $signed(s_tdata[21:11]);
                    val_reg   <= s_tdata[44];
                    page_reg  <= s_tdata[47:45];
                    col_reg   <= s_tdata[54:48];
                    rbyte_reg <= '0;
                    // A single pixel is a line whose end is its start
                    if (in_req == mfle_pkg::REQ_PIXEL) begin
                        xe_reg <= $signed(s_tdata[10:0]);
                        ye_reg <= $signed(s_tdata[21:11]);
                    end else begin
                        xe_reg <= $signed(s_tdata[32:22]);
                        ye_reg <= $signed(s_tdata[43:33]);
                    end
                end
            end
            mfle_pkg::ST_SETUP: begin
                dx_reg    <= diff_x[mfle_pkg::DELTA_W-1] ? unsigned'(-diff_x)
                                                         : unsigned'(diff_x);
                dy_reg    <= diff_y[mfle_pkg::DELTA_W-1] ? unsigned'(-diff_y)
                                                         : unsigned'(diff_y);
                x_neg_reg <= diff_x[mfle_pkg::DELTA_W-1] || (diff_x == '0);
                y_neg_reg <= diff_y[mfle_pkg::DELTA_W-1] || (diff_y == '0);
            end
            mfle_pkg::ST_ERR_INIT: begin
                err_reg <= $signed({2'b00, dx_reg}) - $signed({2'b00, dy_reg});
            end
            mfle_pkg::ST_WALK: begin
                if (!at_end) begin
                    err_reg <= err_sum[mfle_pkg::ERR_W-1:0];
                    if (step_x) x_reg <= x_neg_reg ? x_reg - CW'(1) : x_reg + CW'(1);
                    if (step_y) y_reg <= y_neg_reg ? y_reg - CW'(1) : y_reg + CW'(1);
                end
            end
            mfle_pkg::ST_READ_DATA: begin
                rbyte_reg <= rd_ok ? ram_rdata : '0;
            end
            mfle_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {7'b0, dirty_reg, rbyte_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/mfle_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-old on collision).
module mfle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/mfle_checker.sv =====
// Port-level checker of the line engine and its bind to the top level.
module mfle_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mfle_pkg::OUT_DATA_W-1:0] m_tdata
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset starts the clearing pass, so no request is taken right after it
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("ready right after reset");

    // One request at a time: the engine is busy after taking a beat
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready in the cycle after an accepted beat");

    // A new result only appears while the engine was finishing a request
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind mono_framebuffer_line_engine mfle_checker u_mfle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
